[hdl/integer_matrix_multiply_unit_defines.svh]
// assertion macros for the integer matrix multiply unit
// used by the port checker, expects aclk and aresetn in scope
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define IMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define IMM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/imm_pkg.sv]
// shared types and constants of the integer matrix multiply unit
// no dependencies
package imm_pkg;

    localparam int DATA_W    = 32;
    localparam int ROW_W     = 3;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_WR_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_MULTIPLY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    // one issued multiply-accumulate step
    typedef struct packed {
        logic valid;
        logic first;
        logic fin;
    } imm_step_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } imm_state_t;

endpackage

[hdl/imm_store.sv]
// one matrix store: single write port, single registered read port
// depends on imm_pkg
module imm_store
    import imm_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/imm_mac.sv]
// shared multiply-accumulate unit, product and sum wrap to 32 bits
// depends on imm_pkg
module imm_mac
    import imm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  imm_step_t         step,
    input  logic [DATA_W-1:0] a_data,
    input  logic [DATA_W-1:0] b_data,
    output logic [DATA_W-1:0] acc,
    output logic              done
);

    imm_step_t         step_d1_reg;
    imm_step_t         step_d2_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic              done_reg;
    logic [2*DATA_W-1:0] prod_full;

    // low half of the product is the same signed or unsigned
    assign prod_full = a_data * b_data;
    assign acc_next  = step_d2_reg.first ? prod_reg : acc_reg + prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_d1_reg <= '0;
            step_d2_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            step_d1_reg <= step;
            step_d2_reg <= step_d1_reg;
            done_reg    <= step_d2_reg.valid & step_d2_reg.fin;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[DATA_W-1:0];
        if (step_d2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

[hdl/imm_seq.sv]
// sequencer: walks result rows, columns and the inner index
// depends on imm_pkg
module imm_seq
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int IDX_W   = 3,
    parameter int ADDR_W  = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [IDX_W-1:0]  last_i,
    input  logic [IDX_W-1:0]  last_k,
    input  logic [IDX_W-1:0]  last_j,
    input  logic              mac_done,
    input  logic              out_taken,
    output logic              idle,
    output imm_step_t         step,
    output logic [ADDR_W-1:0] a_addr,
    output logic [ADDR_W-1:0] b_addr,
    output logic [IDX_W-1:0]  cur_i,
    output logic [IDX_W-1:0]  cur_j,
    output logic              last_elem
);

    imm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             k_end;

    assign k_end     = (k_reg == last_k);
    assign last_elem = (i_reg == last_i) && (j_reg == last_j);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_RUN;
            ST_RUN:   if (k_end) state_next = ST_DRAIN;
            ST_DRAIN: if (mac_done) state_next = ST_HOLD;
            ST_HOLD: begin
                if (out_taken) begin
                    state_next = last_elem ? ST_IDLE : ST_RUN;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idle       = 1'b0;
        step       = '0;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idle   = 1'b1;
                i_next = '0;
                j_next = '0;
                k_next = '0;
            end
            ST_RUN: begin
                step.valid = 1'b1;
                step.first = (k_reg == '0);
                step.fin   = k_end;
                k_next     = k_end ? '0 : k_reg + 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_HOLD: begin
                if (out_taken && !last_elem) begin
                    if (j_reg == last_j) begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // row-major store addresses
    assign a_addr = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign b_addr = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);
    assign cur_i  = i_reg;
    assign cur_j  = j_reg;

endmodule

[hdl/integer_matrix_multiply_unit.sv]
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata row, col, element; tuser op
// m_        out  m_tvalid/m_tready  tdata out_row, out_col, product; tlast last
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// a write word does not hold the input; the block stays ready for the next word
// a multiply word keeps the input busy until its last result element is taken;
// the elements run one by one on the single shared multiply-accumulate unit
// reset (aresetn low, synchronous) clears control and sets each dimension to 8;
// stores are not cleared and read as undefined until written
// the next result element is not started until the current one is taken
// top level: stores, sequencer and shared mac of the integer matrix multiplier
// depends on imm_pkg, imm_store, imm_mac, imm_seq
module integer_matrix_multiply_unit
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // wr_row[2:0], wr_col[5:3], element[37:6]
    input  logic [OP_W-1:0]      s_tuser,   // op[1:0]
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_row[2:0], out_col[5:3], product[37:6]
    output logic                 m_tlast,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WA_W   = ROW_W + ADDR_W;

    // dimension registers
    logic [CFG_W-1:0] rows_reg, inner_reg, cols_reg;

    // input word fields
    logic [ROW_W-1:0]  in_row, in_col;
    logic [DATA_W-1:0] in_element;
    logic              in_accept;
    logic              in_range;
    logic [WA_W-1:0]   wr_addr_wide;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_first, wr_second;

    // sequencer and mac wiring
    imm_step_t         step;
    logic [ADDR_W-1:0] a_addr, b_addr;
    logic [DATA_W-1:0] a_data, b_data;
    logic [DATA_W-1:0] acc;
    logic              mac_done;
    logic              seq_idle;
    logic [IDX_W-1:0]  cur_i, cur_j;
    logic              last_elem;
    logic [IDX_W-1:0]  last_i, last_k, last_j;
    logic              out_taken;

    // output register
    logic              m_valid_reg;
    logic [ROW_W-1:0]  out_row_reg, out_col_reg;
    logic [DATA_W-1:0] product_reg;
    logic              last_reg;

    // zero acts as one, above MAX_DIM acts as MAX_DIM; returns count minus one
    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] dim);
        logic [IDX_W-1:0] res;
        if (dim == '0) begin
            res = '0;
        end else if (int'(dim) > MAX_DIM) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(dim - 1'b1);
        end
        return res;
    endfunction

    assign last_i = dim_last(rows_reg);
    assign last_k = dim_last(inner_reg);
    assign last_j = dim_last(cols_reg);

    // configuration, indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= CFG_DIM_RESET;
            inner_reg <= CFG_DIM_RESET;
            cols_reg  <= CFG_DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROWS:  rows_reg  <= cfg_data;
                CFG_INNER: inner_reg <= cfg_data;
                CFG_COLS:  cols_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input side: writes go straight to the stores
    assign in_row     = s_tdata[ROW_W-1:0];
    assign in_col     = s_tdata[2*ROW_W-1:ROW_W];
    assign in_element = s_tdata[2*ROW_W+DATA_W-1:2*ROW_W];
    assign s_tready   = seq_idle;
    assign in_accept  = s_tvalid && s_tready;

    // a write outside the store is dropped
    assign in_range     = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign wr_addr_wide = WA_W'(in_row) * WA_W'(MAX_DIM) + WA_W'(in_col);
    assign wr_addr      = wr_addr_wide[ADDR_W-1:0];
    assign wr_first     = in_accept && in_range && (s_tuser == OP_WR_FIRST);
    assign wr_second    = in_accept && in_range && (s_tuser == OP_WR_SECOND);

    imm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_first_store (
        .aclk    (aclk),
        .wr_en   (wr_first),
        .wr_addr (wr_addr),
        .wr_data (in_element),
        .rd_addr (a_addr),
        .rd_data (a_data)
    );

    imm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_second_store (
        .aclk    (aclk),
        .wr_en   (wr_second),
        .wr_addr (wr_addr),
        .wr_data (in_element),
        .rd_addr (b_addr),
        .rd_data (b_data)
    );

    // sequencer issues one inner step per cycle, then waits for the result
    imm_seq #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_accept && (s_tuser == OP_MULTIPLY)),
        .last_i    (last_i),
        .last_k    (last_k),
        .last_j    (last_j),
        .mac_done  (mac_done),
        .out_taken (out_taken),
        .idle      (seq_idle),
        .step      (step),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .cur_i     (cur_i),
        .cur_j     (cur_j),
        .last_elem (last_elem)
    );

    // step control is delayed inside the mac to line up with store read data
    imm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .a_data  (a_data),
        .b_data  (b_data),
        .acc     (acc),
        .done    (mac_done)
    );

    // output register, loaded once per result element
    assign out_taken = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (mac_done) begin
            m_valid_reg <= 1'b1;
        end else if (out_taken) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_done) begin
            out_row_reg <= ROW_W'(cur_i);
            out_col_reg <= ROW_W'(cur_j);
            product_reg <= acc;
            last_reg    <= last_elem;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*ROW_W - DATA_W){1'b0}},
                       product_reg, out_col_reg, out_row_reg};
    assign m_tlast  = last_reg;

endmodule

[hdl/imm_check.sv]
// port-level checker for the integer matrix multiply unit, bound to the top
// depends on imm_pkg and integer_matrix_multiply_unit_defines.svh
`include "integer_matrix_multiply_unit_defines.svh"

module imm_check
    import imm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [OP_W-1:0]      s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // no new word is taken while a result waits
    `IMM_ASSERT(a_busy_out, m_tvalid |-> !s_tready, "input ready while result pending")

    // a multiply word blocks the input on the next cycle
    `IMM_ASSERT(a_mul_busy, (s_tvalid && s_tready && (s_tuser == OP_MULTIPLY)) |=> !s_tready, "ready right after multiply")

    // each result element is computed afresh after the previous one is taken
    `IMM_ASSERT(a_gap, (m_tvalid && m_tready) |=> !m_tvalid, "back to back result words")

    // a stalled result word holds
    `IMM_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

    // a reset clears any offered result
    `IMM_ASSERT_ALWAYS(a_rst, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind integer_matrix_multiply_unit imm_check u_imm_check (.*);
